// File: rtl/core/mgb_pkg.sv
// Shared types and constants for the mono glyph blitter.
// No dependencies; every other file of the block imports this package.
package mgb_pkg;

  // Fixed field widths
  localparam int unsigned CoordW    = 13;
  localparam int unsigned ScrW      = 13;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned GlyphCfgW = 7;
  localparam int unsigned FmtW      = 2;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  // Screen position of a byte, one bit wider than a coordinate
  localparam int unsigned PosW      = CoordW + 1;
  // Row start in pixels: y * screen_width
  localparam int unsigned RowW      = PosW + ScrW;

  // One lane for each pixel of a bitmap byte
  localparam int unsigned Lanes     = 8;
  localparam int unsigned LaneIdxW  = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPixelFormat  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPixelColor   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgGlyphWidth   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgGlyphHeight  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgFrameBase    = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgFrameValid   = 3'd7;

  // Pixel format codes
  localparam logic [FmtW-1:0] Fmt8  = 2'd0;
  localparam logic [FmtW-1:0] Fmt16 = 2'd1;
  localparam logic [FmtW-1:0] Fmt24 = 2'd2;
  localparam logic [FmtW-1:0] Fmt32 = 2'd3;

  // Input word
  typedef struct packed {
    logic [7:0]        bitmap_byte;
    logic              start_req;
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
  } mgb_in_t;

  // Output word: one framebuffer write
  typedef struct packed {
    logic [AddrW-1:0]  write_address;
    logic [ColorW-1:0] write_data;
    logic [1:0]        byte_count;
    logic              last;
  } mgb_out_t;

  // A byte placed on the screen grid, handed from the position stage to the lanes
  typedef struct packed {
    logic [PosW-1:0] x0;
    logic [PosW-1:0] y;
    logic [7:0]      bits;
  } mgb_pos_item_t;

endpackage

// File: rtl/core/mgb_pos.sv
// Position tracker: latches the glyph origin, walks byte column and row,
// and registers each drawable byte with its screen position. Uses mgb_pkg.
module mgb_pos import mgb_pkg::*; #(
  parameter int unsigned MAX_GLYPH_DIM = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [GlyphCfgW-1:0] glyph_width_i,
  input  logic [GlyphCfgW-1:0] glyph_height_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mgb_in_t              in_word_i,
  output logic                 s1_valid_o,
  output mgb_pos_item_t        s1_item_o,
  input  logic                 s1_take_i
);

  localparam int unsigned DimW = $clog2(MAX_GLYPH_DIM + 1);
  localparam int unsigned ExtW = (DimW > GlyphCfgW) ? DimW : GlyphCfgW;
  localparam int unsigned ColW = $clog2(MAX_GLYPH_DIM / 8 + 1);

  logic [ColW-1:0]   col_q, col_d;
  logic [DimW-1:0]   row_q, row_d;
  logic [CoordW-1:0] lx_q, lx_d;
  logic [CoordW-1:0] ly_q, ly_d;
  logic              active_q, active_d;
  logic              s1_valid_q, s1_valid_d;
  mgb_pos_item_t     s1_item_q, s1_item_d;

  logic              accept;
  logic [ExtW-1:0]   w_ext, h_ext;
  logic [DimW-1:0]   eff_w, eff_h;
  logic [DimW:0]     w_round;
  logic [ColW-1:0]   bpr;

  // Saturate glyph geometry and derive bytes per row
  always_comb begin
    w_ext   = ExtW'(glyph_width_i);
    h_ext   = ExtW'(glyph_height_i);
    eff_w   = (w_ext > ExtW'(MAX_GLYPH_DIM)) ? DimW'(MAX_GLYPH_DIM) : w_ext[DimW-1:0];
    eff_h   = (h_ext > ExtW'(MAX_GLYPH_DIM)) ? DimW'(MAX_GLYPH_DIM) : h_ext[DimW-1:0];
    w_round = {1'b0, eff_w} + (DimW+1)'(7);
    bpr     = ColW'(w_round >> 3);
  end

  assign accept     = in_valid_i && (!s1_valid_q || s1_take_i);
  assign in_stall_o = s1_valid_q && !s1_take_i;

  // Advance the glyph walk on each accepted word
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    lx_d       = lx_q;
    ly_d       = ly_q;
    active_d   = active_q;
    s1_item_d  = s1_item_q;
    s1_valid_d = s1_valid_q && !s1_take_i;
    if (accept) begin
      if (in_word_i.start_req) begin
        lx_d     = in_word_i.origin_x;
        ly_d     = in_word_i.origin_y;
        col_d    = '0;
        row_d    = '0;
        active_d = 1'b1;
      end
      if (active_d) begin
        if ((bpr == '0) || (row_d >= eff_h)) begin
          // empty glyph or walked past the last row: drop the word
          active_d = 1'b0;
        end else begin
          s1_valid_d     = 1'b1;
          s1_item_d.x0   = PosW'(lx_d) + PosW'({col_d, 3'b000});
          s1_item_d.y    = PosW'(ly_d) + PosW'(row_d);
          s1_item_d.bits = in_word_i.bitmap_byte;
          col_d          = col_d + ColW'(1);
          if (col_d >= bpr) begin
            col_d = '0;
            row_d = row_d + DimW'(1);
            if (row_d >= eff_h) begin
              active_d = 1'b0;
            end
          end
        end
      end
    end
  end

  // Hold walk state and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      lx_q       <= '0;
      ly_q       <= '0;
      active_q   <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      lx_q       <= lx_d;
      ly_q       <= ly_d;
      active_q   <= active_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;

`ifndef ASSERT_OFF
  // A word waiting for the lanes must not change under it
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_take_i |=> s1_valid_q && $stable(s1_item_q))
    else $error("position stage changed while held");
`endif

endmodule

// File: rtl/core/mgb_lane.sv
// One pixel lane: places a bitmap bit on its column and clips it to the
// screen width. Uses mgb_pkg.
module mgb_lane import mgb_pkg::*; #(
  parameter int unsigned LANE = 0
) (
  input  logic [PosW-1:0] x0_i,
  input  logic            bit_i,
  input  logic [ScrW-1:0] screen_width_i,
  output logic            hit_o
);

  logic [PosW-1:0] x;

  // Column of this lane and horizontal clip
  assign x     = x0_i + PosW'(LANE);
  assign hit_o = bit_i && (x < PosW'(screen_width_i));

endmodule

// File: rtl/core/mgb_merge.sv
// Merge stage: holds the lane hit mask of one byte and issues its writes
// left to right through an output register. Uses mgb_pkg.
module mgb_merge import mgb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FmtW-1:0]   pixel_format_i,
  input  logic [ColorW-1:0] pixel_color_i,
  input  logic [AddrW-1:0]  frame_base_i,
  input  logic              load_valid_i,
  input  logic [Lanes-1:0]  mask_i,
  input  logic [PosW-1:0]   x0_i,
  input  logic [RowW-1:0]   row_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mgb_out_t          out_word_o
);

  logic                ser_valid_q, ser_valid_d;
  logic [Lanes-1:0]    ser_mask_q, ser_mask_d;
  logic [PosW-1:0]     ser_x0_q;
  logic [RowW-1:0]     ser_row_q;
  logic                out_valid_q, out_valid_d;
  mgb_out_t            out_q, out_d;

  logic [LaneIdxW-1:0] sel;
  logic [Lanes-1:0]    rest;
  logic                last;
  logic                out_adv;
  logic                load;
  logic [AddrW-1:0]    pix, scaled;

  // Pick the leftmost pending lane
  always_comb begin
    sel = '0;
    for (int i = Lanes - 1; i >= 0; i--) begin
      if (ser_mask_q[i]) begin
        sel = LaneIdxW'(i);
      end
    end
  end

  assign rest = ser_mask_q & ~(Lanes'(1) << sel);
  assign last = (rest == '0);

  assign out_adv = ser_valid_q && (!out_valid_q || !out_stall_i);
  assign ready_o = !ser_valid_q || (out_adv && last);
  assign load    = load_valid_i && ready_o;

  // Address and colour of the selected pixel
  always_comb begin
    pix = AddrW'(ser_row_q) + AddrW'(ser_x0_q) + AddrW'(sel);
    out_d.last = last;
    case (pixel_format_i)
      Fmt8: begin
        scaled           = pix;
        out_d.write_data = {16'h0000, pixel_color_i[7:0]};
        out_d.byte_count = 2'd1;
      end
      Fmt16: begin
        scaled           = pix << 1;
        out_d.write_data = {8'h00, pixel_color_i[15:0]};
        out_d.byte_count = 2'd2;
      end
      Fmt24: begin
        scaled           = pix + (pix << 1);
        out_d.write_data = pixel_color_i;
        out_d.byte_count = 2'd3;
      end
      default: begin
        scaled           = pix << 2;
        out_d.write_data = pixel_color_i;
        out_d.byte_count = 2'd3;
      end
    endcase
    out_d.write_address = frame_base_i + scaled;
  end

  // Serializer and output valid
  always_comb begin
    ser_valid_d = ser_valid_q;
    ser_mask_d  = ser_mask_q;
    if (load) begin
      ser_valid_d = 1'b1;
      ser_mask_d  = mask_i;
    end else if (out_adv) begin
      ser_mask_d = rest;
      if (last) begin
        ser_valid_d = 1'b0;
      end
    end
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_mask_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ser_valid_q <= ser_valid_d;
      ser_mask_q  <= ser_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      ser_x0_q  <= x0_i;
      ser_row_q <= row_i;
    end
    if (out_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  // A held byte always has a pixel left to write
  a_mask_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_valid_q |-> (ser_mask_q != '0))
    else $error("serializer holds an empty mask");

  // A write that is not the last leaves the byte in the serializer
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_adv && !last |=> ser_valid_q && ($countones(ser_mask_q) == $countones($past(rest))))
    else $error("serializer lost pixels of a byte");
`endif

endmodule

// File: rtl/core/mono_glyph_blitter.sv
// Mono glyph blitter top: config registers, position tracker, eight clip lanes,
// row multiplier and write merge stage. Uses mgb_pkg, mgb_pos, mgb_lane, mgb_merge.
// The first write of a byte passes the position register, serializer and output
// register. One write per cycle from the single merge stage while the output is not
// stalled; a byte with nothing visible is dropped. Reset is asynchronous,
// active low: no glyph in progress, all pipeline stages empty, config at defaults.
module mono_glyph_blitter import mgb_pkg::*; #(
  parameter int unsigned MAX_GLYPH_DIM = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mgb_in_t             in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mgb_out_t            out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [ScrW-1:0]      screen_width_q;
  logic [ScrW-1:0]      screen_height_q;
  logic [FmtW-1:0]      pixel_format_q;
  logic [ColorW-1:0]    pixel_color_q;
  logic [GlyphCfgW-1:0] glyph_width_q;
  logic [GlyphCfgW-1:0] glyph_height_q;
  logic [AddrW-1:0]     frame_base_q;
  logic                 frame_valid_q;

  logic                 s1_valid;
  mgb_pos_item_t        s1_item;
  logic                 s1_take;
  logic [Lanes-1:0]     hit;
  logic [Lanes-1:0]     mask;
  logic                 y_ok;
  logic [RowW-1:0]      row;
  logic                 merge_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= ScrW'(640);
      screen_height_q <= ScrW'(480);
      pixel_format_q  <= Fmt32;
      pixel_color_q   <= ColorW'(24'hFFFFFF);
      glyph_width_q   <= GlyphCfgW'(8);
      glyph_height_q  <= GlyphCfgW'(16);
      frame_base_q    <= '0;
      frame_valid_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgScreenWidth:  screen_width_q  <= cfg_data_i[ScrW-1:0];
        CfgScreenHeight: screen_height_q <= cfg_data_i[ScrW-1:0];
        CfgPixelFormat:  pixel_format_q  <= cfg_data_i[FmtW-1:0];
        CfgPixelColor:   pixel_color_q   <= cfg_data_i[ColorW-1:0];
        CfgGlyphWidth:   glyph_width_q   <= cfg_data_i[GlyphCfgW-1:0];
        CfgGlyphHeight:  glyph_height_q  <= cfg_data_i[GlyphCfgW-1:0];
        CfgFrameBase:    frame_base_q    <= cfg_data_i[AddrW-1:0];
        CfgFrameValid:   frame_valid_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Glyph walk and byte placement
  mgb_pos #(
    .MAX_GLYPH_DIM (MAX_GLYPH_DIM)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .glyph_width_i  (glyph_width_q),
    .glyph_height_i (glyph_height_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_word_i      (in_word_i),
    .s1_valid_o     (s1_valid),
    .s1_item_o      (s1_item),
    .s1_take_i      (s1_take)
  );

  // Horizontal clip, one lane per pixel; lane 0 takes bit 7
  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    mgb_lane #(
      .LANE (i)
    ) u_lane (
      .x0_i           (s1_item.x0),
      .bit_i          (s1_item.bits[Lanes-1-i]),
      .screen_width_i (screen_width_q),
      .hit_o          (hit[i])
    );
  end

  // Vertical clip, frame gate and row start
  assign y_ok = frame_valid_q && (s1_item.y < PosW'(screen_height_q));
  assign mask = hit & {Lanes{y_ok}};
  assign row  = RowW'(s1_item.y) * RowW'(screen_width_q);

  // Drop bytes with nothing visible, else wait for the merge stage
  assign s1_take = s1_valid && ((mask == '0) || merge_ready);

  mgb_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_format_i (pixel_format_q),
    .pixel_color_i  (pixel_color_q),
    .frame_base_i   (frame_base_q),
    .load_valid_i   (s1_valid && (mask != '0)),
    .mask_i         (mask),
    .x0_i           (s1_item.x0),
    .row_i          (row),
    .ready_o        (merge_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_word_o     (out_word_o)
  );

endmodule
